// ===== rtl/bcpe_pkg.sv =====
// Shared types, constants and curve tables for the battery charge percent estimator.
package bcpe_pkg;

  localparam int unsigned SenseW   = 12;
  localparam int unsigned MvW      = 16;
  localparam int unsigned PctW     = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned CurvePoints = 15;
  localparam int unsigned SegW        = 4;   // holds 0..CurvePoints
  localparam int unsigned AboveW      = 8;   // offset inside one segment, below 150
  localparam int unsigned PspanW      = 4;   // percent rise of one segment, at most 10
  localparam int unsigned ProdW       = 11;  // offset times percent rise, below 1500
  localparam int unsigned RecipW      = 12;  // floor(2^16 / span)
  localparam int unsigned RecipShift  = 16;
  localparam int unsigned QuotW       = 4;   // quotient, at most 10

  localparam logic [SenseW-1:0] ThresholdReset = SenseW'(100);
  localparam logic [MvW-1:0]    EmptyReset     = MvW'(3300);
  localparam logic [MvW-1:0]    FullReset      = MvW'(4200);

  localparam logic [PctW-1:0] PctOne  = PctW'(1);
  localparam logic [PctW-1:0] PctFull = PctW'(100);
  localparam logic [PctW-1:0] PctZero = PctW'(0);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHARGE_THRESHOLD = 2'd0,
    CFG_EMPTY_MV         = 2'd1,
    CFG_FULL_MV          = 2'd2
  } cfg_idx_e;

  // How the final percent is formed.
  typedef enum logic [1:0] {
    KIND_CHARGE = 2'd0,
    KIND_ONE    = 2'd1,
    KIND_FULL   = 2'd2,
    KIND_CURVE  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [SenseW-1:0] sense_sample;
    logic [MvW-1:0]    pack_mv;
  } in_t;

  typedef struct packed {
    logic            on_charge;
    logic [PctW-1:0] percent;
  } out_t;

  // Constants of one curve segment, addressed by the index of its upper point.
  typedef struct packed {
    logic [MvW-1:0]    base_mv;
    logic [PctW-1:0]   base_pct;
    logic [AboveW-1:0] span;
    logic [PspanW-1:0] pspan;
    logic [RecipW-1:0] recip;
  } seg_t;

  function automatic logic [MvW-1:0] curve_mv(input logic [SegW-1:0] idx);
    logic [MvW-1:0] mv;
    case (idx)
      4'd0:    mv = 16'd3300;
      4'd1:    mv = 16'd3400;
      4'd2:    mv = 16'd3550;
      4'd3:    mv = 16'd3650;
      4'd4:    mv = 16'd3700;
      4'd5:    mv = 16'd3740;
      4'd6:    mv = 16'd3760;
      4'd7:    mv = 16'd3780;
      4'd8:    mv = 16'd3800;
      4'd9:    mv = 16'd3850;
      4'd10:   mv = 16'd3900;
      4'd11:   mv = 16'd3950;
      4'd12:   mv = 16'd4000;
      4'd13:   mv = 16'd4100;
      4'd14:   mv = 16'd4200;
      default: mv = 16'hFFFF;
    endcase
    return mv;
  endfunction

  function automatic seg_t seg_lookup(input logic [SegW-1:0] seg);
    seg_t s;
    case (seg)
      4'd1:    s = '{16'd3300, 7'd0,  8'd100, 4'd3,  12'd655};
      4'd2:    s = '{16'd3400, 7'd3,  8'd150, 4'd4,  12'd436};
      4'd3:    s = '{16'd3550, 7'd7,  8'd100, 4'd5,  12'd655};
      4'd4:    s = '{16'd3650, 7'd12, 8'd50,  4'd6,  12'd1310};
      4'd5:    s = '{16'd3700, 7'd18, 8'd40,  4'd7,  12'd1638};
      4'd6:    s = '{16'd3740, 7'd25, 8'd20,  4'd7,  12'd3276};
      4'd7:    s = '{16'd3760, 7'd32, 8'd20,  4'd8,  12'd3276};
      4'd8:    s = '{16'd3780, 7'd40, 8'd20,  4'd8,  12'd3276};
      4'd9:    s = '{16'd3800, 7'd48, 8'd50,  4'd7,  12'd1310};
      4'd10:   s = '{16'd3850, 7'd55, 8'd50,  4'd7,  12'd1310};
      4'd11:   s = '{16'd3900, 7'd62, 8'd50,  4'd8,  12'd1310};
      4'd12:   s = '{16'd3950, 7'd70, 8'd50,  4'd10, 12'd1310};
      4'd13:   s = '{16'd4000, 7'd80, 8'd100, 4'd10, 12'd655};
      4'd14:   s = '{16'd4100, 7'd90, 8'd100, 4'd10, 12'd655};
      default: s = '{16'd0,    7'd0,  8'd1,   4'd0,  12'd0};
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/battery_charge_percent_estimator_unit.sv =====
// Top level of the battery charge percent estimator: a four-stage pipeline.
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+--------------------------------------
//   input    | in_valid_i   | in_stall_o   | in_data_i  (sense_sample, pack_mv)
//   output   | out_valid_o  | out_stall_i  | out_data_o (on_charge, percent)
//   config   | cfg_we_i     | (none)       | cfg_idx_i, cfg_wdata_i
//
// Each accepted item moves from the stage 1 register through stages 2 and 3 to the output register,
// and the pipeline accepts one item in every cycle while the output is not stalled.
// The depth is set by the interpolation: segment search, offset multiply,
// reciprocal multiply, then remainder correction and final selection.
// Reset clears the stage valid bits and loads the window registers with
// 100, 3300 mV and 4200 mV. A stalled output holds its item, and each stage
// holds while the one after it is full and cannot move, so no item is lost.
module battery_charge_percent_estimator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bcpe_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [bcpe_pkg::CfgDataW-1:0]        cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bcpe_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bcpe_pkg::out_t                       out_data_o
);
  import bcpe_pkg::*;

  // Configuration registers.
  logic [SenseW-1:0] thr_q;
  logic [MvW-1:0]    empty_q;
  logic [MvW-1:0]    full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThresholdReset;
      empty_q <= EmptyReset;
      full_q  <= FullReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHARGE_THRESHOLD: thr_q   <= cfg_wdata_i[SenseW-1:0];
        CFG_EMPTY_MV:         empty_q <= cfg_wdata_i;
        CFG_FULL_MV:          full_q  <= cfg_wdata_i;
        default:              ;
      endcase
    end
  end

  // Stage valid bits and the ready chain. A stage may load when it is empty
  // or when its item moves on in the same cycle.
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4       = !out_valid_q || !out_stall_i;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) s1_valid_q  <= in_valid_i;
      if (rdy2) s2_valid_q  <= s1_valid_q;
      if (rdy3) s3_valid_q  <= s2_valid_q;
      if (rdy4) out_valid_q <= s3_valid_q;
    end
  end

  // Stage 1: classify the item and find the curve segment. The segment index
  // is the number of curve points at or below the pack voltage; zero means
  // below the curve and the full count means at or above its top.
  logic [CurvePoints-1:0] at_or_above;
  logic [SegW-1:0]        seg_d;
  kind_e                  kind1_d;

  always_comb begin
    for (int i = 0; i < CurvePoints; i++) begin
      at_or_above[i] = in_data_i.pack_mv >= curve_mv(SegW'(i));
    end
    seg_d = SegW'($countones(at_or_above));
    if (in_data_i.sense_sample < thr_q) begin
      kind1_d = KIND_CHARGE;
    end else if (full_q <= empty_q || in_data_i.pack_mv <= empty_q) begin
      kind1_d = KIND_ONE;
    end else if (in_data_i.pack_mv >= full_q) begin
      kind1_d = KIND_FULL;
    end else if (seg_d == '0) begin
      kind1_d = KIND_ONE;
    end else if (seg_d == SegW'(CurvePoints)) begin
      kind1_d = KIND_FULL;
    end else begin
      kind1_d = KIND_CURVE;
    end
  end

  kind_e          kind1_q;
  logic [SegW-1:0] seg1_q;
  logic [MvW-1:0]  mv1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      kind1_q <= kind1_d;
      seg1_q  <= seg_d;
      mv1_q   <= in_data_i.pack_mv;
    end
  end

  // Stage 2: offset into the segment times the segment's percent rise.
  seg_t              seg1_info;
  logic [MvW-1:0]    above_full;
  logic [ProdW-1:0]  prod2_d;

  always_comb begin
    seg1_info  = seg_lookup(seg1_q);
    above_full = mv1_q - seg1_info.base_mv;
    prod2_d    = ProdW'(above_full[AboveW-1:0] * seg1_info.pspan);
  end

  kind_e            kind2_q;
  logic [SegW-1:0]  seg2_q;
  logic [ProdW-1:0] prod2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      kind2_q <= kind1_q;
      seg2_q  <= seg1_q;
      prod2_q <= prod2_d;
    end
  end

  // Stage 3: estimate the quotient by the floor reciprocal of the span. The
  // estimate is the true quotient or one less.
  seg_t                          seg2_info;
  logic [ProdW+RecipW-1:0]       recip_prod;
  logic [QuotW-1:0]              q3_d;

  always_comb begin
    seg2_info  = seg_lookup(seg2_q);
    recip_prod = (ProdW+RecipW)'(prod2_q * seg2_info.recip);
    q3_d       = recip_prod[RecipShift+QuotW-1:RecipShift];
  end

  kind_e            kind3_q;
  logic [SegW-1:0]  seg3_q;
  logic [ProdW-1:0] prod3_q;
  logic [QuotW-1:0] q3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      kind3_q <= kind2_q;
      seg3_q  <= seg2_q;
      prod3_q <= prod2_q;
      q3_q    <= q3_d;
    end
  end

  // Stage 4: correct the quotient from the remainder, add the segment base,
  // floor at one and pick the result for the item's kind.
  seg_t              seg3_info;
  logic [ProdW:0]    back_prod;
  logic [ProdW:0]    rem;
  logic [QuotW-1:0]  quot;
  logic [PctW-1:0]   curve_pct;
  out_t              out_d;

  always_comb begin
    seg3_info = seg_lookup(seg3_q);
    back_prod = (ProdW+1)'(q3_q * seg3_info.span);
    rem       = {1'b0, prod3_q} - back_prod;
    quot      = (rem >= (ProdW+1)'(seg3_info.span)) ? q3_q + QuotW'(1) : q3_q;
    curve_pct = seg3_info.base_pct + PctW'(quot);
    if (curve_pct == PctZero) curve_pct = PctOne;
    out_d.on_charge = 1'b0;
    case (kind3_q)
      KIND_CHARGE: begin
        out_d.on_charge = 1'b1;
        out_d.percent   = PctZero;
      end
      KIND_ONE:   out_d.percent = PctOne;
      KIND_FULL:  out_d.percent = PctFull;
      KIND_CURVE: out_d.percent = curve_pct;
      default:    out_d.percent = PctOne;
    endcase
  end

  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The charging sentinel is the only zero percent.
  a_charge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.on_charge |-> out_data_o.percent == PctZero)
    else $error("charging item carries a nonzero percent");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.on_charge |->
      out_data_o.percent >= PctOne && out_data_o.percent <= PctFull)
    else $error("discharging percent out of range");

  // The reciprocal estimate never exceeds the segment's percent rise.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && kind3_q == KIND_CURVE |-> q3_q <= seg3_info.pspan)
    else $error("quotient estimate exceeds segment rise");

  // A full stage that cannot move keeps its item.
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !rdy4 |=> s3_valid_q && $stable(q3_q) && $stable(kind3_q))
    else $error("stalled stage dropped or changed its item");

endmodule
